// ===== hw/rtl/deq_pkg.sv =====
// deq_pkg: shared types and constants for the double-ended queue
// request and response payload structs, request and status codes, store sizes
// no dependencies
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // request codes
    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_POP_FRONT  = 2'd1,
        REQ_PUSH_BACK  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } req_code_t;

    // status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [1:0] ST_PUSH_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] push_value;
    } req_t;

    typedef struct packed {
        logic [31:0] front_value;
        logic [31:0] back_value;
        logic [4:0]  entry_count;
        logic        is_empty;
        logic        is_full;
        logic [1:0]  status;
    } rsp_t;

endpackage

// ===== hw/rtl/deq_ram.sv =====
// deq_ram: generic single-write, single-read memory with registered read data
// no dependencies
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/double_ended_queue_top.sv =====
// double_ended_queue_top: bounded deque held in a circular store
// depends on deq_pkg and deq_ram (two copies of the store, one per read port)
//
// channel   | handshake     | payload
// ----------+---------------+---------------------------------------------
// request   | start / busy  | req  (req_type, push_value)
// response  | done strobe   | rsp  (front, back, count, empty, full, status)
//
// a request runs in order: the transfer cycle updates pointers and writes
// the store, S_READ reads front and back slots into the registered ram outputs,
// and S_RESP presents the response; done pulses for one cycle while the next
// request may already be taken, so a new request may overlap the last response
// reset clears pointers and count; the store itself is not cleared
// the receiver cannot stall, so done never waits
module double_ended_queue_top
    import deq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_RESP
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   head_reg, head_next;
    logic [ADDR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [1:0]          status_reg, status_next;

    logic                accept;
    logic                is_full_now;
    logic                is_empty_now;
    logic [ADDR_W-1:0]   head_prev;
    logic [ADDR_W-1:0]   head_succ;
    logic [ADDR_W-1:0]   tail_prev;
    logic [ADDR_W-1:0]   tail_succ;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                ram_re;
    logic [DATA_WIDTH-1:0] front_q;
    logic [DATA_WIDTH-1:0] back_q;

    assign busy   = (state_reg == S_READ);
    assign accept = start && !busy;

    // circular index neighbors
    assign head_prev = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - 1'b1;
    assign head_succ = (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_prev = (tail_reg == '0) ? ADDR_W'(DEPTH - 1) : tail_reg - 1'b1;
    assign tail_succ = (tail_reg == ADDR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    assign is_full_now  = (count_reg == CNT_W'(DEPTH));
    assign is_empty_now = (count_reg == '0);

    // request decode: pointer, count and store write
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = tail_reg;
        ram_wdata   = DATA_WIDTH'(req.push_value);
        if (accept)
        begin
            status_next = ST_DONE;
            unique case (req_code_t'(req.req_type))
                REQ_PUSH_FRONT:
                begin
                    if (is_full_now)
                    begin
                        status_next = ST_PUSH_FULL;
                    end
                    else
                    begin
                        head_next  = head_prev;
                        ram_we     = 1'b1;
                        ram_waddr  = head_prev;
                        count_next = count_reg + 1'b1;
                    end
                end
                REQ_PUSH_BACK:
                begin
                    if (is_full_now)
                    begin
                        status_next = ST_PUSH_FULL;
                    end
                    else
                    begin
                        tail_next  = tail_succ;
                        ram_we     = 1'b1;
                        ram_waddr  = tail_reg;
                        count_next = count_reg + 1'b1;
                    end
                end
                REQ_POP_FRONT:
                begin
                    if (is_empty_now)
                    begin
                        status_next = ST_POP_EMPTY;
                    end
                    else
                    begin
                        head_next  = head_succ;
                        count_next = count_reg - 1'b1;
                    end
                end
                REQ_POP_BACK:
                begin
                    if (is_empty_now)
                    begin
                        status_next = ST_POP_EMPTY;
                    end
                    else
                    begin
                        tail_next  = tail_prev;
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    // sequencer: transfer, read, respond
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = accept ? S_READ : S_IDLE;
            S_READ:  state_next = S_RESP;
            S_RESP:  state_next = accept ? S_READ : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            status_reg <= ST_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    // store copies: one read port for the front, one for the back
    assign ram_re = (state_reg == S_READ);

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_front_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (front_q)
    );

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_back_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (tail_prev),
        .rdata (back_q)
    );

    // response assembly; empty queue reads as zero
    assign done = (state_reg == S_RESP);

    always_comb
    begin
        rsp.front_value = is_empty_now ? '0 : 32'(front_q);
        rsp.back_value  = is_empty_now ? '0 : 32'(back_q);
        rsp.entry_count = 5'(count_reg);
        rsp.is_empty    = is_empty_now;
        rsp.is_full     = is_full_now;
        rsp.status      = status_reg;
    end

    // count stays within the store
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
    else $error("entry count beyond store depth");

    // a response always follows a read cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_READ))
    else $error("response without a preceding read");

    // one transfer moves the count by at most one
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (count_reg == $past(count_reg)) ||
                   (count_reg == $past(count_reg) + 1'b1) ||
                   (count_reg == $past(count_reg) - 1'b1))
    else $error("count moved by more than one");

    // a rejected request leaves the count alone
    assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status != ST_DONE) |-> $stable(count_reg) || $past(accept))
    else $error("rejected request changed the count");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking testbench for double_ended_queue_top, directed then random requests
// keeps its own deque model in a small class and checks every done strobe against it
// depends on deq_pkg and the double_ended_queue_top rtl
module tb_top
    import deq_pkg::*;
();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 225;

    // deque model and expected response store
    class deque_tracker;
        logic [DATA_WIDTH-1:0] slots[DEPTH];
        int    head_slot;
        int    tail_slot;
        int    entries;
        int    errors;
        rsp_t  awaited_views[$];

        // apply one accepted request to the model and queue the view it should produce
        function void note_request(req_t r);
            rsp_t       view;
            logic [1:0] code;
            view = '0;
            code = ST_DONE;
            case (req_code_t'(r.req_type))
                REQ_PUSH_FRONT, REQ_PUSH_BACK:
                begin
                    if (entries >= DEPTH)
                    begin
                        code = ST_PUSH_FULL;
                    end
                    else if (req_code_t'(r.req_type) == REQ_PUSH_FRONT)
                    begin
                        head_slot = (head_slot == 0) ? DEPTH - 1 : head_slot - 1;
                        slots[head_slot] = r.push_value[DATA_WIDTH-1:0];
                        entries++;
                    end
                    else
                    begin
                        slots[tail_slot] = r.push_value[DATA_WIDTH-1:0];
                        tail_slot = (tail_slot + 1 == DEPTH) ? 0 : tail_slot + 1;
                        entries++;
                    end
                end
                default:
                begin
                    if (entries == 0)
                    begin
                        code = ST_POP_EMPTY;
                    end
                    else if (req_code_t'(r.req_type) == REQ_POP_FRONT)
                    begin
                        head_slot = (head_slot + 1 == DEPTH) ? 0 : head_slot + 1;
                        entries--;
                    end
                    else
                    begin
                        tail_slot = (tail_slot == 0) ? DEPTH - 1 : tail_slot - 1;
                        entries--;
                    end
                end
            endcase
            // front and back read as zero on an empty queue
            if (entries != 0)
            begin
                view.front_value = slots[head_slot];
                view.back_value  = slots[(tail_slot == 0) ? DEPTH - 1 : tail_slot - 1];
            end
            view.entry_count = entries[4:0];
            view.is_empty    = (entries == 0);
            view.is_full     = (entries >= DEPTH);
            view.status      = code;
            awaited_views.push_back(view);
        endfunction

        // compare one response transfer with the oldest expected view
        function void check_response(rsp_t got);
            rsp_t want;
            if (awaited_views.size() == 0)
            begin
                $error("response with nothing expected: %h", got);
                errors++;
                return;
            end
            want = awaited_views.pop_front();
            if (got.front_value !== want.front_value)
            begin
                $error("front_value: expected %h, actual %h", want.front_value, got.front_value);
                errors++;
            end
            if (got.back_value !== want.back_value)
            begin
                $error("back_value: expected %h, actual %h", want.back_value, got.back_value);
                errors++;
            end
            if (got.entry_count !== want.entry_count)
            begin
                $error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
                errors++;
            end
            if (got.is_empty !== want.is_empty)
            begin
                $error("is_empty: expected %b, actual %b", want.is_empty, got.is_empty);
                errors++;
            end
            if (got.is_full !== want.is_full)
            begin
                $error("is_full: expected %b, actual %b", want.is_full, got.is_full);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
        endfunction

        function int outstanding();
            return awaited_views.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;

    deque_tracker book = new();
    int idle_pct;
    int cycle_count;

    double_ended_queue_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // response monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            book.check_response(rsp);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic req_t make_req(req_code_t code, logic [31:0] value);
        req_t r;
        r.req_type   = code;
        r.push_value = value;
        return r;
    endfunction

    // one request transfer, with an optional idle gap in front
    task automatic send_request(req_t r);
        int gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 3) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
        book.note_request(r);
    endtask

    // hold off until every expected response has arrived
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (book.outstanding() != 0);
    endtask

    // random requests in stretches that lean toward filling, toward draining or neither
    task automatic run_random(int count);
        int        push_pct;
        logic [31:0] value;
        req_code_t code;
        push_pct = 50;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: push_pct = 15;
                    1: push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            case ($urandom_range(0, 7))
                0: value = '0;
                1: value = '1;
                default: value = $urandom;
            endcase
            if ($urandom_range(0, 99) < push_pct)
            begin
                code = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
            end
            else
            begin
                code = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
            end
            send_request(make_req(code, value));
        end
    endtask

    // main sequence
    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        idle_pct    = 0;
        cycle_count = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pops on an empty queue, single entry at both ends
        send_request(make_req(REQ_POP_FRONT, 32'h1234_5678));
        send_request(make_req(REQ_POP_BACK, 32'hFFFF_FFFF));
        send_request(make_req(REQ_PUSH_FRONT, 32'hFFFF_FFFF));
        send_request(make_req(REQ_PUSH_BACK, 32'h0000_0000));
        send_request(make_req(REQ_POP_FRONT, 32'h0));
        send_request(make_req(REQ_POP_BACK, 32'h0));

        // fill from both ends, then pushes on a full queue
        for (int i = 0; i < DEPTH; i++)
        begin
            send_request(make_req(i[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT,
                                  i[1] ? 32'hAAAA_AAAA ^ i : 32'h5555_5555 ^ i));
        end
        send_request(make_req(REQ_PUSH_FRONT, 32'hDEAD_BEEF));
        send_request(make_req(REQ_PUSH_BACK, 32'hFFFF_FFFF));
        drain();

        // random phases: sparse gaps, frequent gaps, back to back
        idle_pct = 10;
        run_random(RANDOM_ITEMS);
        drain();
        idle_pct = 63;
        run_random(RANDOM_ITEMS);
        drain();
        idle_pct = 0;
        run_random(RANDOM_ITEMS);

        drain();
        repeat (8) @(posedge clk);
        if (book.errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/deq_pkg.sv
hw/rtl/deq_ram.sv
hw/rtl/double_ended_queue_top.sv
test/tb_top.sv
